// File: rtl/core/lpw_pkg.sv
// shared types and constants for the line point walker
`timescale 1ns / 1ps
package lpw_pkg;
   localparam logic [1:0] CMD_LOAD_A = 2'd0;
   localparam logic [1:0] CMD_LOAD_B = 2'd1;
   localparam logic [1:0] CMD_STEP   = 2'd2;

   localparam logic [1:0] REG_RED   = 2'd0;
   localparam logic [1:0] REG_GREEN = 2'd1;
   localparam logic [1:0] REG_BLUE  = 2'd2;

   localparam int GAIN_W = 17;
   localparam int COL_W  = 19;
   localparam int ATTR_W = 32;
   localparam int DIV_W  = 36;   // signed numerator width of the step divider

   // controller to datapath
   typedef struct packed {
      logic load_a;
      logic setup_b;    // latch ordered ends, deltas, start current point
      logic div_start;  // begin the step division of one attribute
      logic [1:0] div_sel;
      logic walk;       // emit current point and take one step
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic last;
   } status_type;
endpackage

// File: rtl/core/lpw_div.sv
// signed restoring divider, one quotient bit per cycle, truncates toward zero
`timescale 1ns / 1ps
module lpw_div #(
   parameter int DEN_W = 17
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [lpw_pkg::DIV_W-1:0] num,
   input  logic [DEN_W-1:0]              den,
   output logic                          done,
   output logic [lpw_pkg::ATTR_W-1:0]    quot
);
   localparam int NW = lpw_pkg::DIV_W;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0]    q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic             neg_ff, neg_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W+1:0] trial;
   logic [NW-1:0]    qres;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[NW-1]} - {2'b00, d_ff};
      if (start) begin
         q_in = num[NW-1] ? NW'(-num) : NW'(num);
         neg_in = num[NW-1];
         r_in = '0; d_in = den;
         cnt_in = CW'(NW); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DEN_W+1]) begin
            r_in = trial[DEN_W:0];
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[DEN_W-1:0], q_ff[NW-1]};
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in;
   end

   assign qres = neg_ff ? -q_ff : q_ff;
   assign quot = qres[lpw_pkg::ATTR_W-1:0];
   assign done = done_ff;
endmodule

// File: rtl/core/lpw_ctrl.sv
// controller state machine: loads, division sequencing and point issue
`timescale 1ns / 1ps
module lpw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_command,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  lpw_pkg::status_type stat,
   output lpw_pkg::cmd_type    cmd
);
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_START = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_NEXT  = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic       active_ff, active_in;
   logic       ovalid_ff, ovalid_in;
   logic       accept;

   // output register frees when empty or being taken
   assign req_stall = (state_ff != ST_IDLE) || (ovalid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = ovalid_ff;

   always_comb begin
      state_in = state_ff; sel_in = sel_ff; active_in = active_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      cmd = '0;
      cmd.div_sel = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  lpw_pkg::CMD_LOAD_A: cmd.load_a = 1'b1;
                  lpw_pkg::CMD_LOAD_B: begin
                     cmd.setup_b = 1'b1; sel_in = '0; state_in = ST_START;
                     active_in = 1'b1;
                  end
                  lpw_pkg::CMD_STEP: begin
                     if (active_ff) begin
                        cmd.walk = 1'b1; ovalid_in = 1'b1;
                        if (stat.last) active_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_START: begin
            cmd.div_start = 1'b1; state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (stat.div_done) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (sel_ff == 2'd3) state_in = ST_IDLE;
            else begin
               sel_in = sel_ff + 2'd1; state_in = ST_START;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; sel_ff <= '0; active_ff <= 1'b0; ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; sel_ff <= sel_in; active_ff <= active_in;
         ovalid_ff <= ovalid_in;
      end
   end
endmodule

// File: rtl/core/lpw_dpath.sv
// datapath: endpoint store, bresenham stepper, attribute accumulators, output register
`timescale 1ns / 1ps
module lpw_dpath #(
   parameter int COORD_BITS     = 16,
   parameter int ATTR_FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lpw_pkg::cmd_type                 cmd,
   output lpw_pkg::status_type              stat,
   input  logic                             csr_write,
   input  logic [1:0]                       csr_index,
   input  logic [lpw_pkg::GAIN_W-1:0]       csr_data,
   input  logic signed [COORD_BITS-1:0]     req_x_coord,
   input  logic signed [COORD_BITS-1:0]     req_y_coord,
   input  logic signed [lpw_pkg::ATTR_W-1:0] req_depth_in,
   input  logic [lpw_pkg::GAIN_W-1:0]       req_red_in,
   input  logic [lpw_pkg::GAIN_W-1:0]       req_green_in,
   input  logic [lpw_pkg::GAIN_W-1:0]       req_blue_in,
   output logic signed [COORD_BITS-1:0]     rsp_px,
   output logic signed [COORD_BITS-1:0]     rsp_py,
   output logic signed [lpw_pkg::ATTR_W-1:0] rsp_depth_out,
   output logic signed [lpw_pkg::COL_W-1:0] rsp_red_out,
   output logic signed [lpw_pkg::COL_W-1:0] rsp_green_out,
   output logic signed [lpw_pkg::COL_W-1:0] rsp_blue_out,
   output logic signed [lpw_pkg::COL_W-1:0] rsp_ambient_red_out,
   output logic signed [lpw_pkg::COL_W-1:0] rsp_ambient_green_out,
   output logic signed [lpw_pkg::COL_W-1:0] rsp_ambient_blue_out,
   output logic                             rsp_last_point
);
   localparam int CB = COORD_BITS;
   localparam int DW = CB + 1;
   localparam int EW = CB + 2;
   localparam int AW = lpw_pkg::ATTR_W;
   localparam int GW = lpw_pkg::GAIN_W;
   localparam int CW = lpw_pkg::COL_W;
   localparam int NW = lpw_pkg::DIV_W;
   localparam int PW = AW + GW;
   localparam logic signed [AW-1:0] COL_MAX = AW'(131072);
   localparam logic signed [AW-1:0] COL_MIN = -AW'(131072);

   logic [GW-1:0] gain_ff [3];
   logic signed [CB-1:0] ax_ff, ay_ff;
   logic [AW-1:0]  aattr_ff [4];
   logic [AW-1:0]  lattr_ff [4], gattr_ff [4];
   logic [CB-1:0]  cx_ff, cy_ff, endm_ff;
   logic signed [EW-1:0] err_ff;
   logic [DW-1:0]  maj_ff, min_ff;
   logic           ydir_ff, xmaj_ff;
   logic [AW-1:0]  cur_ff [4], stp_ff [4];

   // output register
   logic [CB-1:0]  opx_ff, opy_ff;
   logic [AW-1:0]  odep_ff;
   logic [CW-1:0]  ocol_ff [3], oamb_ff [3];
   logic           olast_ff;

   // load b combinational setup
   logic swap;
   logic signed [CB-1:0] lx, ly, gx, gy;
   logic signed [DW-1:0] dx, dy, md;
   logic [AW-1:0] ba [4];
   logic xmaj;

   assign ba[0] = req_depth_in;
   assign ba[1] = AW'(req_red_in);
   assign ba[2] = AW'(req_green_in);
   assign ba[3] = AW'(req_blue_in);

   always_comb begin
      swap = req_x_coord < ax_ff;
      lx = swap ? req_x_coord : ax_ff;  ly = swap ? req_y_coord : ay_ff;
      gx = swap ? ax_ff : req_x_coord;  gy = swap ? ay_ff : req_y_coord;
      dx = {gx[CB-1], gx} - {lx[CB-1], lx};
      dy = (gy > ly) ? ({gy[CB-1], gy} - {ly[CB-1], ly})
                     : ({ly[CB-1], ly} - {gy[CB-1], gy});
      xmaj = dx > dy;
      md = xmaj ? dx : dy;
   end

   // attribute step divisions share one divider
   logic signed [NW-1:0] dnum;
   logic [AW-1:0] quot;
   logic div_done;
   always_comb begin
      dnum = NW'($signed(gattr_ff[cmd.div_sel])) - NW'($signed(lattr_ff[cmd.div_sel]));
      if (cmd.div_sel != 2'd0)
         dnum = $signed(NW'(gattr_ff[cmd.div_sel][GW-1:0]))
              - $signed(NW'(lattr_ff[cmd.div_sel][GW-1:0]));
   end

   lpw_div #(.DEN_W(DW)) u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .num(dnum),
      .den(maj_ff), .done(div_done), .quot(quot)
   );

   // bresenham step
   logic [CB-1:0] cmaj, ystep;
   logic signed [EW-1:0] e1;
   logic last;
   assign cmaj  = xmaj_ff ? cx_ff : cy_ff;
   assign last  = cmaj == endm_ff;
   assign ystep = ydir_ff ? '1 : CB'(1);
   assign e1    = err_ff - $signed({1'b0, min_ff});

   assign stat.div_done = div_done;
   assign stat.last     = last;

   // colour saturation and ambient product
   function automatic logic [CW-1:0] sat(input logic signed [AW-1:0] v);
      if (v > COL_MAX) sat = CW'(COL_MAX);
      else if (v < COL_MIN) sat = CW'(COL_MIN);
      else sat = v[CW-1:0];
   endfunction

   logic [AW-1:0] mag [3];
   logic [PW-1:0] prod [3];
   logic [PW-1:0] shr [3];
   logic signed [AW:0] amb [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i]  = cur_ff[i+1][AW-1] ? -cur_ff[i+1] : cur_ff[i+1];
         prod[i] = PW'(mag[i]) * PW'(gain_ff[i]);
         shr[i]  = prod[i] >> ATTR_FRAC_BITS;
         // clamp magnitude before negating
         amb[i]  = (shr[i] > PW'(131072)) ? (AW+1)'(131072) : (AW+1)'(shr[i]);
         if (cur_ff[i+1][AW-1]) amb[i] = -amb[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) gain_ff[i] <= GW'(65536);
         ax_ff <= '0; ay_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            aattr_ff[i] <= '0; cur_ff[i] <= '0; stp_ff[i] <= '0;
         end
         cx_ff <= '0; cy_ff <= '0; endm_ff <= '0; err_ff <= '0;
         maj_ff <= '0; min_ff <= '0; ydir_ff <= 1'b0; xmaj_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               lpw_pkg::REG_RED:   gain_ff[0] <= csr_data;
               lpw_pkg::REG_GREEN: gain_ff[1] <= csr_data;
               lpw_pkg::REG_BLUE:  gain_ff[2] <= csr_data;
               default: ;
            endcase
         end
         if (cmd.load_a) begin
            ax_ff <= req_x_coord; ay_ff <= req_y_coord;
            for (int i = 0; i < 4; i++) aattr_ff[i] <= ba[i];
         end
         if (cmd.setup_b) begin
            for (int i = 0; i < 4; i++) begin
               lattr_ff[i] <= swap ? ba[i] : aattr_ff[i];
               gattr_ff[i] <= swap ? aattr_ff[i] : ba[i];
               cur_ff[i]   <= swap ? ba[i] : aattr_ff[i];
            end
            ydir_ff <= !(ly < gy);
            xmaj_ff <= xmaj;
            maj_ff  <= md;
            min_ff  <= xmaj ? dy : dx;
            err_ff  <= EW'(md >>> 1);
            cx_ff   <= lx; cy_ff <= ly;
            endm_ff <= xmaj ? gx : gy;
         end
         if (div_done)
            stp_ff[cmd.div_sel] <= (maj_ff == '0) ? '0 : quot;
         if (cmd.walk) begin
            if (xmaj_ff) begin
               cx_ff <= cx_ff + CB'(1);
               if (e1 < 0) cy_ff <= cy_ff + ystep;
            end else begin
               cy_ff <= cy_ff + ystep;
               if (e1 < 0) cx_ff <= cx_ff + CB'(1);
            end
            err_ff <= (e1 < 0) ? e1 + $signed({1'b0, maj_ff}) : e1;
            for (int i = 0; i < 4; i++) cur_ff[i] <= cur_ff[i] + stp_ff[i];
         end
      end
      if (cmd.walk) begin
         opx_ff <= cx_ff; opy_ff <= cy_ff; odep_ff <= cur_ff[0];
         for (int i = 0; i < 3; i++) begin
            ocol_ff[i] <= sat(cur_ff[i+1]);
            oamb_ff[i] <= amb[i][CW-1:0];
         end
         olast_ff <= last;
      end
   end

   assign rsp_px = opx_ff;
   assign rsp_py = opy_ff;
   assign rsp_depth_out = odep_ff;
   assign rsp_red_out = ocol_ff[0];
   assign rsp_green_out = ocol_ff[1];
   assign rsp_blue_out = ocol_ff[2];
   assign rsp_ambient_red_out = oamb_ff[0];
   assign rsp_ambient_green_out = oamb_ff[1];
   assign rsp_ambient_blue_out = oamb_ff[2];
   assign rsp_last_point = olast_ff;
endmodule

// File: rtl/core/line_point_walker_with_shading.sv
// top level of the shaded line point walker
//  channel  dir  handshake           payload
//  req      in   req_valid/stall     command, endpoint x, y, depth, colour
//  rsp      out  rsp_valid/stall     point, depth, colour, ambient colour, last
//  csr      in   csr_write           csr_index, csr_data
// a load B item holds the input stalled while one shared bit-serial divider
// forms the four attribute steps, one quotient bit a cycle.
// synchronous active-high reset clears the walker to idle with unity gains.
// the input stalls while the result register holds an item that is stalled.
`timescale 1ns / 1ps
module line_point_walker_with_shading #(
   parameter int COORD_BITS     = 16,
   parameter int ATTR_FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [16:0]                 csr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_command,
   input  logic signed [COORD_BITS-1:0] req_x_coord,
   input  logic signed [COORD_BITS-1:0] req_y_coord,
   input  logic signed [31:0]          req_depth_in,
   input  logic [16:0]                 req_red_in,
   input  logic [16:0]                 req_green_in,
   input  logic [16:0]                 req_blue_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_px,
   output logic signed [COORD_BITS-1:0] rsp_py,
   output logic signed [31:0]          rsp_depth_out,
   output logic signed [18:0]          rsp_red_out,
   output logic signed [18:0]          rsp_green_out,
   output logic signed [18:0]          rsp_blue_out,
   output logic signed [18:0]          rsp_ambient_red_out,
   output logic signed [18:0]          rsp_ambient_green_out,
   output logic signed [18:0]          rsp_ambient_blue_out,
   output logic                        rsp_last_point
);
   lpw_pkg::cmd_type    cmd;
   lpw_pkg::status_type stat;

   lpw_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .stat(stat), .cmd(cmd)
   );

   lpw_dpath #(.COORD_BITS(COORD_BITS), .ATTR_FRAC_BITS(ATTR_FRAC_BITS)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_x_coord(req_x_coord), .req_y_coord(req_y_coord),
      .req_depth_in(req_depth_in), .req_red_in(req_red_in),
      .req_green_in(req_green_in), .req_blue_in(req_blue_in),
      .rsp_px(rsp_px), .rsp_py(rsp_py), .rsp_depth_out(rsp_depth_out),
      .rsp_red_out(rsp_red_out), .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out), .rsp_ambient_red_out(rsp_ambient_red_out),
      .rsp_ambient_green_out(rsp_ambient_green_out),
      .rsp_ambient_blue_out(rsp_ambient_blue_out), .rsp_last_point(rsp_last_point)
   );

   // a point is issued only from an accepted step item
   a_walk_needs_step: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> (req_valid && !req_stall && req_command == lpw_pkg::CMD_STEP))
      else $error("point issued without step item");

   // a new point never overwrites a stalled result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !cmd.walk)
      else $error("result overwritten while stalled");

   // input is held off after load B setup starts the divider sequence
   a_setup_stalls: assert property (@(posedge clock) disable iff (reset)
      cmd.setup_b |=> req_stall)
      else $error("input open during step division");
endmodule
